[design/i2c_master_bit_engine_defines.svh]
// ----------------------------------------------------------------------------
// i2c master bit engine assertion macros
// shared assertion forms clocked on clk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// checked only while out of reset
`define I2CMBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define I2CMBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/i2cmbe_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared codes, state and item types of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int DATA_BITS = 8;
  localparam int BIT_CNT_W = $clog2(DATA_BITS + 1);
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // action codes
  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_WACK  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;
  localparam logic [2:0] ACT_TICK  = 3'd5;

  // register word index
  localparam logic REG_PHASE_TICKS = 1'b0;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WACK  = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [2:0]           phase_step;
    logic [BIT_CNT_W-1:0] bit_count;
    logic [DATA_BITS-1:0] shift_reg;
    logic [7:0]           tick_count;
    logic                 scl_level;
    logic                 sda_level;
    logic                 nack_flag;
    logic                 ack_choice;
    logic [DATA_BITS-1:0] last_read;
  } engine_state_t;

  localparam engine_state_t STATE_RESET = '{
    op:         OP_IDLE,
    phase_step: 3'd0,
    bit_count:  '0,
    shift_reg:  '0,
    tick_count: 8'd0,
    scl_level:  1'b1,
    sda_level:  1'b1,
    nack_flag:  1'b0,
    ack_choice: 1'b0,
    last_read:  '0
  };

  typedef struct packed {
    logic [2:0]           action;
    logic [DATA_BITS-1:0] data_byte;
    logic                 send_ack;
    logic                 sda_in;
  } item_t;

  typedef struct packed {
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] read_data;
    logic                 nack_seen;
    logic                 command_dropped;
  } result_t;

endpackage

[design/i2cmbe_step.sv]
// ----------------------------------------------------------------------------
// i2cmbe_step
// next state and result of the bit engine for one command or tick transfer
// ----------------------------------------------------------------------------
module i2cmbe_step (
  input  i2cmbe_pkg::engine_state_t state,
  input  i2cmbe_pkg::item_t         item,
  input  logic [7:0]                phase_ticks,
  output i2cmbe_pkg::engine_state_t state_next,
  output i2cmbe_pkg::result_t       result
);
  import i2cmbe_pkg::*;

  engine_state_t        nxt;
  logic                 done;
  logic                 dropped;
  logic                 seq_end;
  logic [7:0]           limit;
  logic [7:0]           tick_inc;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [DATA_BITS-1:0] shift_out;
  logic [DATA_BITS-1:0] shift_in;

  assign limit     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign tick_inc  = state.tick_count + 8'd1;
  assign bit_inc   = state.bit_count + BIT_CNT_W'(1);
  assign shift_out = {state.shift_reg[DATA_BITS-2:0], 1'b0};
  assign shift_in  = {state.shift_reg[DATA_BITS-2:0], item.sda_in};

  always_comb begin
    nxt     = state;
    done    = 1'b0;
    dropped = 1'b0;
    seq_end = 1'b0;
    if (item.action <= ACT_READ) begin
      if (state.op != OP_IDLE) begin
        dropped = 1'b1;
      end else begin
        nxt.phase_step = 3'd0;
        nxt.tick_count = 8'd0;
        nxt.bit_count  = '0;
        case (item.action)
          ACT_START: begin
            nxt.op        = OP_START;
            nxt.sda_level = 1'b1;
            nxt.scl_level = 1'b1;
          end
          ACT_STOP: begin
            nxt.op        = OP_STOP;
            nxt.sda_level = 1'b0;
          end
          ACT_WRITE: begin
            nxt.op        = OP_WRITE;
            nxt.shift_reg = item.data_byte;
            nxt.sda_level = item.data_byte[DATA_BITS-1];
          end
          ACT_WACK: begin
            nxt.op        = OP_WACK;
            nxt.nack_flag = 1'b0;
            nxt.sda_level = 1'b1;
          end
          default: begin
            nxt.op         = OP_READ;
            nxt.ack_choice = item.send_ack;
            nxt.shift_reg  = '0;
            nxt.sda_level  = 1'b1;
            nxt.scl_level  = 1'b1;
          end
        endcase
      end
    end else if (item.action == ACT_TICK && state.op != OP_IDLE) begin
      if (tick_inc >= limit) begin
        nxt.tick_count = 8'd0;
        case (state.op)
          OP_START: begin
            case (state.phase_step)
              3'd0: begin
                nxt.sda_level  = 1'b0;
                nxt.phase_step = 3'd1;
              end
              3'd1: begin
                nxt.scl_level  = 1'b0;
                nxt.phase_step = 3'd2;
              end
              default: seq_end = 1'b1;
            endcase
          end
          OP_STOP: begin
            case (state.phase_step)
              3'd0: begin
                nxt.scl_level  = 1'b1;
                nxt.phase_step = 3'd1;
              end
              3'd1: begin
                nxt.sda_level  = 1'b1;
                nxt.phase_step = 3'd2;
              end
              default: seq_end = 1'b1;
            endcase
          end
          OP_WACK: begin
            case (state.phase_step)
              3'd0: begin
                nxt.scl_level  = 1'b1;
                nxt.phase_step = 3'd1;
              end
              3'd1: begin
                if (item.sda_in) begin
                  nxt.nack_flag  = 1'b1;
                  nxt.sda_level  = 1'b0;
                  nxt.phase_step = 3'd2;
                end else begin
                  nxt.scl_level  = 1'b0;
                  nxt.phase_step = 3'd5;
                end
              end
              3'd2: begin
                nxt.scl_level  = 1'b1;
                nxt.phase_step = 3'd3;
              end
              3'd3: begin
                nxt.sda_level  = 1'b1;
                nxt.phase_step = 3'd4;
              end
              default: seq_end = 1'b1;
            endcase
          end
          OP_WRITE: begin
            if (state.phase_step == 3'd0) begin
              nxt.scl_level  = 1'b1;
              nxt.phase_step = 3'd1;
            end else begin
              nxt.scl_level = 1'b0;
              nxt.shift_reg = shift_out;
              nxt.bit_count = bit_inc;
              if (bit_inc < BIT_CNT_W'(DATA_BITS)) begin
                nxt.sda_level  = shift_out[DATA_BITS-1];
                nxt.phase_step = 3'd0;
              end else begin
                nxt.sda_level = 1'b1;
                seq_end       = 1'b1;
              end
            end
          end
          OP_READ: begin
            case (state.phase_step)
              3'd0: begin
                nxt.shift_reg = shift_in;
                nxt.scl_level = 1'b0;
                nxt.bit_count = bit_inc;
                if (bit_inc >= BIT_CNT_W'(DATA_BITS)) begin
                  nxt.last_read = shift_in;
                end
                nxt.phase_step = 3'd1;
              end
              3'd1: begin
                if (state.bit_count < BIT_CNT_W'(DATA_BITS)) begin
                  nxt.scl_level  = 1'b1;
                  nxt.phase_step = 3'd0;
                end else begin
                  nxt.scl_level  = 1'b0;
                  nxt.phase_step = 3'd2;
                end
              end
              3'd2: begin
                nxt.sda_level  = ~state.ack_choice;
                nxt.phase_step = 3'd3;
              end
              3'd3: begin
                nxt.scl_level  = 1'b1;
                nxt.phase_step = 3'd4;
              end
              default: begin
                nxt.scl_level = 1'b0;
                seq_end       = 1'b1;
              end
            endcase
          end
          default: seq_end = 1'b1;
        endcase
        if (seq_end) begin
          nxt.op         = OP_IDLE;
          nxt.phase_step = 3'd0;
          done           = 1'b1;
        end
      end else begin
        nxt.tick_count = tick_inc;
      end
    end
  end

  assign state_next = nxt;

  assign result.scl_out         = nxt.scl_level;
  assign result.sda_out         = nxt.sda_level;
  assign result.busy_res        = (nxt.op != OP_IDLE);
  assign result.done_res        = done;
  assign result.read_data       = nxt.last_read;
  assign result.nack_seen       = nxt.nack_flag;
  assign result.command_dropped = dropped;

endmodule

[design/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master bit engine: start, stop, write, wait ack and read sequences
// paced by tick transfers, with an apb register for ticks per line phase
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   in       | in        | in_valid/in_stall  | action, data_byte, send_ack, sda_in
//   out      | out       | out_valid/out_stall| scl_out, sda_out, busy_res, ...
//   apb      | in        | psel/penable/pready| paddr, pwdata, prdata
//
// one transfer in and one out per cycle while the output is not stalled; the input
// passes through the input register, then the state update into the result register
// reset sets the lines released, the engine idle and phase_ticks to one
// an out stall holds the result register and backs up into the input register
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           action,
  input  logic [i2cmbe_pkg::DATA_BITS-1:0]     data_byte,
  input  logic                                 send_ack,
  input  logic                                 sda_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 scl_out,
  output logic                                 sda_out,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [i2cmbe_pkg::DATA_BITS-1:0]     read_data,
  output logic                                 nack_seen,
  output logic                                 command_dropped,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cmbe_pkg::PADDR_W-1:0]       paddr,
  input  logic [i2cmbe_pkg::PDATA_W-1:0]       pwdata,
  output logic [i2cmbe_pkg::PDATA_W-1:0]       prdata,
  output logic                                 pready
);
  import i2cmbe_pkg::*;

  `include "i2c_master_bit_engine_defines.svh"

  engine_state_t state;
  engine_state_t state_next;
  item_t         s1_item;
  logic          s1_valid;
  result_t       res;
  result_t       res_next;
  logic          res_valid;
  logic [7:0]    phase_ticks;
  logic          advance;
  logic          in_take;
  logic          cfg_write;

  assign advance   = s1_valid && (!res_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_take   = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  i2cmbe_step u_step (
    .state       (state),
    .item        (s1_item),
    .phase_ticks (phase_ticks),
    .state_next  (state_next),
    .result      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      res_valid   <= 1'b0;
      state       <= STATE_RESET;
      phase_ticks <= PHASE_TICKS_RESET;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_write && paddr[2] == REG_PHASE_TICKS) begin
        phase_ticks <= pwdata[7:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{action: action, data_byte: data_byte, send_ack: send_ack, sda_in: sda_in};
    end
    if (advance) begin
      res <= res_next;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PHASE_TICKS) begin
      prdata = {{(PDATA_W-8){1'b0}}, phase_ticks};
    end
  end

  assign out_valid       = res_valid;
  assign scl_out         = res.scl_out;
  assign sda_out         = res.sda_out;
  assign busy_res        = res.busy_res;
  assign done_res        = res.done_res;
  assign read_data       = res.read_data;
  assign nack_seen       = res.nack_seen;
  assign command_dropped = res.command_dropped;

  `I2CMBE_ASSERT(a_done_not_busy, res_valid && res.done_res |-> !res.busy_res, "done while busy")
  `I2CMBE_ASSERT(a_drop_busy, res_valid && res.command_dropped |-> res.busy_res, "drop while idle")
  `I2CMBE_ASSERT(a_idle_clean, state.op == OP_IDLE |-> state.phase_step == 3'd0 && state.tick_count == 8'd0, "idle state not clean")
  `I2CMBE_ASSERT(a_bit_range, state.bit_count <= BIT_CNT_W'(DATA_BITS), "bit count overrun")
  `I2CMBE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule
